// File: sv/u2d_pkg.sv
`timescale 1ns / 1ps

package u2d_pkg;

  localparam int VALUE_W            = 32;
  localparam int NUM_DIGITS         = 10;
  localparam int BCD_W              = 4 * NUM_DIGITS;
  localparam int COUNT_W            = 4;
  localparam int POS_W              = 4;
  localparam int CHAR_W             = 6;
  localparam int STAGE_BITS_DEFAULT = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Contents of one conversion stage: packed BCD digits built so far and
  // the binary bits not yet shifted in, most significant bit on top.
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] rest;
  } u2d_work_t;

endpackage

// File: sv/u2d_dabble_stage.sv
`timescale 1ns / 1ps

module u2d_dabble_stage import u2d_pkg::*; #(
  parameter int STAGE_BITS = STAGE_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  u2d_work_t in_work,
  output logic      valid,
  output u2d_work_t work
);

  u2d_work_t work_next;

  // Shift-and-add-three over this stage's share of the binary bits.
  always_comb begin
    work_next = in_work;
    for (int s = 0; s < STAGE_BITS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (work_next.bcd[4*d +: 4] >= 4'd5) begin
          work_next.bcd[4*d +: 4] = work_next.bcd[4*d +: 4] + 4'd3;
        end
      end
      work_next.bcd  = {work_next.bcd[BCD_W-2:0], work_next.rest[VALUE_W-1]};
      work_next.rest = {work_next.rest[VALUE_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work <= work_next;
    end
  end

endmodule

// File: sv/u2d_serializer.sv
`timescale 1ns / 1ps

module u2d_serializer import u2d_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [BCD_W-1:0]   in_bcd,
  output logic               ready,
  output logic               strobe,
  output logic [CHAR_W-1:0]  digit_char,
  output logic [COUNT_W-1:0] digit_count,
  output logic               last
);

  logic               active;
  logic [BCD_W-1:0]   bcd;
  logic [COUNT_W-1:0] count;
  logic [POS_W-1:0]   pos;
  logic [COUNT_W-1:0] count_next;
  logic               load;

  // Digit count is the position of the highest nonzero digit plus one.
  always_comb begin
    count_next = COUNT_W'(1);
    for (int d = 1; d < NUM_DIGITS; d++) begin
      if (in_bcd[4*d +: 4] != 4'd0) begin
        count_next = COUNT_W'(d + 1);
      end
    end
  end

  assign ready = !active || (pos == '0);
  assign load  = ready && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      strobe <= active;
      if (active) begin
        last <= (pos == '0);
      end
      if (load) begin
        active <= 1'b1;
      end else if (active && pos == '0) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      digit_char  <= ASCII_ZERO + {2'b00, bcd[4*pos +: 4]};
      digit_count <= count;
    end
    if (load) begin
      bcd   <= in_bcd;
      count <= count_next;
      pos   <= POS_W'(count_next - COUNT_W'(1));
    end else if (active && pos != '0) begin
      pos <= pos - POS_W'(1);
    end
  end

  a_digits_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("digit run of one request broken before its last digit");

  a_count_steady: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> digit_count == $past(digit_count))
    else $error("digit count changed within one request");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (digit_char >= 6'd48) && (digit_char <= 6'd57))
    else $error("character outside the decimal digits");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (digit_count >= 4'd1) && (digit_count <= 4'd10))
    else $error("digit count out of range");

endmodule

// File: sv/uint32_to_decimal_ascii_unit.sv
// A request accepted with the serializer idle passes through the NUM_STAGES
// conversion stages (four by default) before its first character is on the ports.
// The character serializer drives one digit per cycle and so sets the request rate:
// a request holds it for digit_count digits (1 to 10); the stages overlap with it.
// The receiver cannot stall: each character is on the ports for exactly one cycle.
// Reset (rst, synchronous) empties the pipeline and the serializer; no request is kept.
`timescale 1ns / 1ps

module uint32_to_decimal_ascii_unit import u2d_pkg::*; #(
  // Binary bits handled per conversion stage; must divide VALUE_W.
  parameter int STAGE_BITS = STAGE_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value,
  output logic               strobe,
  output logic [CHAR_W-1:0]  digit_char,
  output logic [COUNT_W-1:0] digit_count,
  output logic               last
);

  localparam int NUM_STAGES = VALUE_W / STAGE_BITS;

  // Each stage runs STAGE_BITS shift-and-add-three steps on the packed BCD
  // digits. A stage loads whenever it is empty or its contents move on, so
  // the pipeline compresses bubbles and only backs up behind the serializer.
  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] stage_en;
  logic [NUM_STAGES-1:0] stage_in_valid;
  u2d_work_t             stage_in_work [NUM_STAGES];
  u2d_work_t             stage_work    [NUM_STAGES];
  logic                  ser_ready;

  // A new request enters whenever the first stage can load.
  assign busy = !stage_en[0];

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    if (i == 0) begin : g_head
      assign stage_in_valid[i]     = start;
      assign stage_in_work[i].bcd  = '0;
      assign stage_in_work[i].rest = value;
    end else begin : g_body
      assign stage_in_valid[i] = stage_valid[i-1];
      assign stage_in_work[i]  = stage_work[i-1];
    end

    if (i == NUM_STAGES - 1) begin : g_tail_en
      assign stage_en[i] = !stage_valid[i] || ser_ready;
    end else begin : g_mid_en
      assign stage_en[i] = !stage_valid[i] || stage_en[i+1];
    end

    u2d_dabble_stage #(
      .STAGE_BITS(STAGE_BITS)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .en      (stage_en[i]),
      .in_valid(stage_in_valid[i]),
      .in_work (stage_in_work[i]),
      .valid   (stage_valid[i]),
      .work    (stage_work[i])
    );
  end

  // The serializer takes the finished BCD digits in the cycle it registers the last
  // digit of its previous request, so characters of consecutive requests
  // follow each other with no gap.
  u2d_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (stage_valid[NUM_STAGES-1]),
    .in_bcd     (stage_work[NUM_STAGES-1].bcd),
    .ready      (ser_ready),
    .strobe     (strobe),
    .digit_char (digit_char),
    .digit_count(digit_count),
    .last       (last)
  );

endmodule

// File: verif/digit_text_checker.sv
`timescale 1ns / 1ps

module digit_text_checker import u2d_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [VALUE_W-1:0] value,
  input  logic               strobe,
  input  logic [CHAR_W-1:0]  digit_char,
  input  logic [COUNT_W-1:0] digit_count,
  input  logic               last,
  output int                 errors,
  output int                 pending,
  output int                 chars_checked,
  output int                 values_taken
);

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [COUNT_W-1:0] count;
    logic               last;
  } digit_result_t;

  digit_result_t digit_queue[$];
  int fail_count    = 0;
  int queued_chars  = 0;
  int checked_count = 0;
  int request_count = 0;

  assign errors        = fail_count;
  assign pending       = queued_chars;
  assign chars_checked = checked_count;
  assign values_taken  = request_count;

  // Decimal text of one value, most significant digit first.
  function automatic void queue_decimal_text(input logic [VALUE_W-1:0] number);
    logic [3:0] digits [NUM_DIGITS];
    logic [VALUE_W-1:0] rest;
    int n;
    digit_result_t r;
    rest = number;
    n = 0;
    do begin
      digits[n] = 4'(rest % 10);
      rest = rest / 10;
      n++;
    end while (rest != 0);
    for (int k = n - 1; k >= 0; k--) begin
      r.ch    = CHAR_W'(ASCII_ZERO + digits[k]);
      r.count = COUNT_W'(n);
      r.last  = (k == 0);
      digit_queue.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    digit_result_t exp_r;
    if (rst) begin
      digit_queue.delete();
    end else begin
      if (strobe) begin
        if (digit_queue.size() == 0) begin
          $display("%0t: unexpected character: got char %0d count %0d last %0b",
                   $time, digit_char, digit_count, last);
          fail_count++;
        end else begin
          exp_r = digit_queue.pop_front();
          checked_count++;
          if (digit_char !== exp_r.ch || digit_count !== exp_r.count ||
              last !== exp_r.last) begin
            $display({"%0t: mismatch: expected char %0d count %0d last %0b, ",
                      "got char %0d count %0d last %0b"},
                     $time, exp_r.ch, exp_r.count, exp_r.last,
                     digit_char, digit_count, last);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        queue_decimal_text(value);
        request_count++;
      end
    end
    queued_chars <= digit_queue.size();
  end

endmodule

// File: verif/tb_uint32_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps

module tb_uint32_to_decimal_ascii_unit;
  import u2d_pkg::*;

  // Clock and the single reset at the start of the run.
  logic clk = 1'b0;
  logic rst = 1'b1;

  // Request side, driven from time zero so the block never sees X.
  logic               start = 1'b0;
  logic [VALUE_W-1:0] value = '0;

  // Result side.
  logic               busy;
  logic               strobe;
  logic [CHAR_W-1:0]  digit_char;
  logic [COUNT_W-1:0] digit_count;
  logic               last;

  int errors;
  int pending;
  int chars_checked;
  int values_taken;

  always #10 clk = ~clk;

  uint32_to_decimal_ascii_unit dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .strobe     (strobe),
    .digit_char (digit_char),
    .digit_count(digit_count),
    .last       (last)
  );

  // The checker sees the same ports and predicts every character on its own.
  digit_text_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .strobe       (strobe),
    .digit_char   (digit_char),
    .digit_count  (digit_count),
    .last         (last),
    .errors       (errors),
    .pending      (pending),
    .chars_checked(chars_checked),
    .values_taken (values_taken)
  );

  // No gaps at all while a burst runs, so requests can follow back to back.
  bit burst_mode = 1'b0;

  // Present one request and hold it until the block takes it. Reading busy right
  // after the edge gives the value it had at that edge, which is what the block
  // used to decide on acceptance. start is only raised here and only lowered in
  // the idle phase below and at the end of the run, so it never gets two assignments in one time step.
  task automatic send_request(input logic [VALUE_W-1:0] v);
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
  endtask

  // Idle time after a request: mostly none or a few cycles, now and then long.
  // While idle, value carries junk so that the block must really qualify it.
  task automatic idle_after_request();
    int gap;
    int pick;
    pick = $urandom_range(0, 9);
    if (burst_mode || pick < 5) gap = 0;
    else if (pick < 9) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      value <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A random value whose decimal text has a random length, so that short and
  // long outputs are equally common; some values are fully random or zero.
  function automatic logic [VALUE_W-1:0] random_value();
    logic [63:0] lo;
    logic [63:0] hi;
    int len;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick < 4) return $urandom;
    len = $urandom_range(1, NUM_DIGITS);
    lo = 64'd1;
    repeat (len - 1) lo = lo * 64'd10;
    hi = lo * 64'd10 - 64'd1;
    if (len == 1) lo = 64'd0;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return VALUE_W'($urandom_range(32'(hi), 32'(lo)));
  endfunction

  // Directed values: zero, every digit-length boundary on both sides, the
  // full-scale value and patterns that toggle every input bit.
  logic [VALUE_W-1:0] directed_values[] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
    32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
    32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000,
    32'd999999999, 32'd1000000000, 32'hFFFF_FFFF, 32'h8000_0000,
    32'h5555_5555, 32'hAAAA_AAAA
  };

  localparam int RANDOM_REQUESTS = 430;
  localparam int DRAIN_CYCLES    = 30;

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_values[i]) begin
      send_request(directed_values[i]);
      idle_after_request();
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      // Switch in and out of gap-free bursts every few dozen requests.
      if (i % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      send_request(random_value());
      idle_after_request();
    end

    // Let the checker register the final request before reading its backlog.
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Any stray character after the last expected one shows up here.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d values (every digit length 1 to 10, zero and full scale),",
             values_taken);
    $display("checking %0d characters against the predicted decimal text.",
             chars_checked);
    if (errors == 0) begin
      $display("uint32_to_decimal_ascii_unit test passed");
    end else begin
      $display("uint32_to_decimal_ascii_unit test failed");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is well under a millisecond.
  initial begin
    #20ms;
    $display("Timeout with %0d characters still outstanding.", pending);
    $display("uint32_to_decimal_ascii_unit test failed");
    $finish;
  end

endmodule
